@@ design/kssc_pkg.sv @@
// Shared types and constants for the keyboard scan synth controller.
// Holds the white-key table, the scan codes, the target port codes and the queue record.
// Depends on nothing.
package kssc_pkg;

	// Number of entries in the hardwired white-key table.
	localparam int MAP_DEPTH = 21;
	localparam int DATA_W    = 32;
	localparam int SLOTS     = 4;

	// Prefix and special scan codes.
	localparam logic [7:0] CODE_BREAK  = 8'hF0;
	localparam logic [7:0] CODE_EXTEND = 8'hE0;
	localparam logic [7:0] CODE_ENTER  = 8'h5A;

	// Setting keys.
	localparam logic [7:0] CODE_WAVE    = 8'h16;
	localparam logic [7:0] CODE_VOLUME  = 8'h1E;
	localparam logic [7:0] CODE_VOICES  = 8'h26;
	localparam logic [7:0] CODE_DETUNE  = 8'h25;
	localparam logic [7:0] CODE_CUTOFF  = 8'h2E;
	localparam logic [7:0] CODE_H_ATK   = 8'h36;
	localparam logic [7:0] CODE_H_BODY  = 8'h3D;
	localparam logic [7:0] CODE_H_TAIL  = 8'h3E;
	localparam logic [7:0] CODE_H_NOISE = 8'h46;
	localparam logic [7:0] CODE_E_ATK   = 8'h45;
	localparam logic [7:0] CODE_E_DECAY = 8'h43;
	localparam logic [7:0] CODE_E_SUS   = 8'h44;
	localparam logic [7:0] CODE_E_REL   = 8'h4D;

	// Target port codes.
	localparam logic [2:0] PORT_NOTES   = 3'd0;
	localparam logic [2:0] PORT_CTRL    = 3'd1;
	localparam logic [2:0] PORT_ADSR    = 3'd2;
	localparam logic [2:0] PORT_FILTER  = 3'd3;
	localparam logic [2:0] PORT_PIANO   = 3'd4;
	localparam logic [2:0] PORT_DISPLAY = 3'd5;
	localparam logic [2:0] PORT_LEDS    = 3'd6;
	localparam logic [2:0] PORT_TEST    = 3'd7;

	// Fixed display word shown when Enter is pressed.
	localparam logic [DATA_W-1:0] ENTER_BANNER = 32'h008B_5179;

	// One classified scan code: up to four writes, last_idx marks the final one.
	typedef struct packed {
		logic [SLOTS-1:0][2:0]        port;
		logic [SLOTS-1:0][DATA_W-1:0] data;
		logic [1:0]                   last_idx;
	} rec_t;

	// White-key scan code at a table position.
	function automatic logic [7:0] key_code(input int unsigned idx);
		logic [7:0] c;
		case (idx)
			0:       c = 8'h1A;
			1:       c = 8'h22;
			2:       c = 8'h21;
			3:       c = 8'h2A;
			4:       c = 8'h32;
			5:       c = 8'h31;
			6:       c = 8'h3A;
			7:       c = 8'h1C;
			8:       c = 8'h1B;
			9:       c = 8'h23;
			10:      c = 8'h2B;
			11:      c = 8'h34;
			12:      c = 8'h33;
			13:      c = 8'h3B;
			14:      c = 8'h15;
			15:      c = 8'h1D;
			16:      c = 8'h24;
			17:      c = 8'h2D;
			18:      c = 8'h2C;
			19:      c = 8'h35;
			20:      c = 8'h3C;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ design/kssc_front.sv @@
// Front end: accepts scan codes, keeps the note and synth setting state and
// builds the list of port writes for each code. Depends on kssc_pkg.
module kssc_front import kssc_pkg::*; #(
	parameter int NOTE_KEYS = 21
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] scan_code,
	output logic       push,
	output rec_t       rec
);

	localparam int LIMIT = (NOTE_KEYS < MAP_DEPTH) ? NOTE_KEYS : MAP_DEPTH;

	logic [MAP_DEPTH-1:0] note_q;
	logic                 break_q, extend_q;
	logic [2:0]           wave_q;
	logic [3:0]           volume_q, voices_q, detune_q;
	logic [4:0]           cutoff_q;
	logic [7:0]           e_atk_q, e_decay_q, e_sus_q, e_rel_q;
	logic [7:0]           h_atk_q, h_body_q, h_tail_q, h_noise_q;

	logic [MAP_DEPTH-1:0] hit_vec, note_mask, note_nxt;
	logic                 hit, pending, is_prefix;
	logic [2:0]           wave_nxt;
	logic [3:0]           volume_nxt, voices_nxt, detune_nxt;
	logic [4:0]           cutoff_nxt;
	logic [7:0]           e_atk_nxt, e_decay_nxt, e_sus_nxt, e_rel_nxt;
	logic [7:0]           h_atk_nxt, h_body_nxt, h_tail_nxt, h_noise_nxt;
	logic [DATA_W-1:0]    notes_word, ctrl_word, adsr_word, piano_word, filter_word;
	logic [DATA_W-1:0]    disp_word;
	logic [3:0]           disp_code;
	logic [7:0]           disp_val;
	logic [2:0]           set_port;
	logic                 set_key;

	// Table search; the lowest matching position wins.
	always_comb begin
		hit_vec = '0;
		for (int i = LIMIT - 1; i >= 0; i--) begin
			if (scan_code == key_code(i)) begin
				hit_vec    = '0;
				hit_vec[i] = 1'b1;
			end
		end
		hit = |hit_vec;
		for (int i = 0; i < MAP_DEPTH; i++) begin
			note_mask[i] = (i < NOTE_KEYS);
		end
	end

	assign pending   = break_q | extend_q;
	assign is_prefix = (scan_code == CODE_BREAK) || (scan_code == CODE_EXTEND);

	// Note bitmap after this code, masked to the configured key count.
	always_comb begin
		if (pending) begin
			note_nxt = note_q & ~hit_vec & note_mask;
		end else begin
			note_nxt = (note_q | hit_vec) & note_mask;
		end
	end

	// Setting step rules.
	always_comb begin
		wave_nxt    = wave_q;
		volume_nxt  = volume_q;
		voices_nxt  = voices_q;
		detune_nxt  = detune_q;
		cutoff_nxt  = cutoff_q;
		e_atk_nxt   = e_atk_q;
		e_decay_nxt = e_decay_q;
		e_sus_nxt   = e_sus_q;
		e_rel_nxt   = e_rel_q;
		h_atk_nxt   = h_atk_q;
		h_body_nxt  = h_body_q;
		h_tail_nxt  = h_tail_q;
		h_noise_nxt = h_noise_q;
		set_port    = PORT_DISPLAY;
		set_key     = 1'b0;
		disp_code   = 4'd0;
		disp_val    = 8'd0;
		if (!hit && !pending) begin
			unique case (scan_code)
				CODE_WAVE: begin
					wave_nxt  = (wave_q >= 3'd4) ? 3'd0 : wave_q + 3'd1;
					set_port  = PORT_CTRL;
					set_key   = 1'b1;
					disp_code = 4'd1;
					disp_val  = {5'd0, wave_nxt};
				end
				CODE_VOLUME: begin
					volume_nxt = volume_q + 4'd1;
					set_port   = PORT_CTRL;
					set_key    = 1'b1;
					disp_code  = 4'd2;
					disp_val   = {4'd0, volume_nxt};
				end
				CODE_VOICES: begin
					voices_nxt = (voices_q >= 4'd8) ? 4'd1 : {voices_q[2:0], 1'b0};
					set_port   = PORT_CTRL;
					set_key    = 1'b1;
					disp_code  = 4'd3;
					disp_val   = {4'd0, voices_nxt};
				end
				CODE_DETUNE: begin
					detune_nxt = detune_q + 4'd1;
					set_port   = PORT_CTRL;
					set_key    = 1'b1;
					disp_code  = 4'd4;
					disp_val   = {4'd0, detune_nxt};
				end
				CODE_CUTOFF: begin
					cutoff_nxt = cutoff_q + 5'd1;
					set_port   = PORT_FILTER;
					set_key    = 1'b1;
					disp_code  = 4'd5;
					disp_val   = {3'd0, cutoff_nxt};
				end
				CODE_H_ATK: begin
					h_atk_nxt = h_atk_q + 8'd16;
					set_port  = PORT_PIANO;
					set_key   = 1'b1;
					disp_code = 4'd6;
					disp_val  = h_atk_nxt;
				end
				CODE_H_BODY: begin
					h_body_nxt = h_body_q + 8'd16;
					set_port   = PORT_PIANO;
					set_key    = 1'b1;
					disp_code  = 4'd7;
					disp_val   = h_body_nxt;
				end
				CODE_H_TAIL: begin
					h_tail_nxt = h_tail_q + 8'd8;
					set_port   = PORT_PIANO;
					set_key    = 1'b1;
					disp_code  = 4'd8;
					disp_val   = h_tail_nxt;
				end
				CODE_H_NOISE: begin
					h_noise_nxt = h_noise_q + 8'd16;
					set_port    = PORT_PIANO;
					set_key     = 1'b1;
					disp_code   = 4'd9;
					disp_val    = h_noise_nxt;
				end
				CODE_E_ATK: begin
					e_atk_nxt = e_atk_q + 8'd16;
					set_port  = PORT_ADSR;
					set_key   = 1'b1;
					disp_code = 4'd10;
					disp_val  = e_atk_nxt;
				end
				CODE_E_DECAY: begin
					e_decay_nxt = e_decay_q + 8'd16;
					set_port    = PORT_ADSR;
					set_key     = 1'b1;
					disp_code   = 4'd11;
					disp_val    = e_decay_nxt;
				end
				CODE_E_SUS: begin
					e_sus_nxt = e_sus_q + 8'd16;
					set_port  = PORT_ADSR;
					set_key   = 1'b1;
					disp_code = 4'd12;
					disp_val  = e_sus_nxt;
				end
				CODE_E_REL: begin
					e_rel_nxt = e_rel_q + 8'd16;
					set_port  = PORT_ADSR;
					set_key   = 1'b1;
					disp_code = 4'd13;
					disp_val  = e_rel_nxt;
				end
				default: begin
				end
			endcase
		end
	end

	// Packed words from the updated state.
	assign notes_word  = {{(DATA_W - MAP_DEPTH){1'b0}}, note_nxt};
	assign ctrl_word   = {3'd0, wave_nxt, detune_nxt, voices_nxt, volume_nxt, 14'd0};
	assign adsr_word   = {e_atk_nxt, e_decay_nxt, e_sus_nxt, e_rel_nxt};
	assign piano_word  = {h_atk_nxt, h_body_nxt, h_tail_nxt, h_noise_nxt};
	assign filter_word = {27'd0, cutoff_nxt};
	assign disp_word   = {4'd0, disp_code, 16'd0, disp_val};

	// Write list for this code.
	always_comb begin
		rec          = '0;
		rec.port[0]  = PORT_LEDS;
		rec.data[0]  = notes_word;
		rec.last_idx = 2'd0;
		if (hit) begin
			rec.port[0]  = PORT_NOTES;
			rec.data[0]  = notes_word;
			rec.port[1]  = PORT_DISPLAY;
			rec.data[1]  = notes_word;
			rec.port[2]  = PORT_LEDS;
			rec.data[2]  = notes_word;
			rec.last_idx = 2'd2;
		end else if (!pending) begin
			if (scan_code == CODE_ENTER) begin
				rec.port[0]  = PORT_TEST;
				rec.data[0]  = 32'd1;
				rec.port[1]  = PORT_DISPLAY;
				rec.data[1]  = ENTER_BANNER;
				rec.port[2]  = PORT_DISPLAY;
				rec.data[2]  = '0;
				rec.port[3]  = PORT_LEDS;
				rec.data[3]  = notes_word;
				rec.last_idx = 2'd3;
			end else if (set_key) begin
				rec.port[0] = set_port;
				unique case (set_port)
					PORT_CTRL:   rec.data[0] = ctrl_word;
					PORT_ADSR:   rec.data[0] = adsr_word;
					PORT_FILTER: rec.data[0] = filter_word;
					default:     rec.data[0] = piano_word;
				endcase
				rec.port[1]  = PORT_DISPLAY;
				rec.data[1]  = disp_word;
				rec.port[2]  = PORT_LEDS;
				rec.data[2]  = notes_word;
				rec.last_idx = 2'd2;
			end else begin
				rec.port[0]  = PORT_DISPLAY;
				rec.data[0]  = '0;
				rec.port[1]  = PORT_LEDS;
				rec.data[1]  = notes_word;
				rec.last_idx = 2'd1;
			end
		end
	end

	assign push = accept && !is_prefix;

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_q    <= '0;
			break_q   <= 1'b0;
			extend_q  <= 1'b0;
			wave_q    <= 3'd0;
			volume_q  <= 4'd8;
			voices_q  <= 4'd4;
			detune_q  <= 4'd7;
			cutoff_q  <= 5'd16;
			e_atk_q   <= 8'd20;
			e_decay_q <= 8'd100;
			e_sus_q   <= 8'd255;
			e_rel_q   <= 8'd100;
			h_atk_q   <= 8'd128;
			h_body_q  <= 8'd200;
			h_tail_q  <= 8'd16;
			h_noise_q <= 8'd128;
		end else if (accept) begin
			if (scan_code == CODE_BREAK) begin
				break_q <= 1'b1;
			end else if (scan_code == CODE_EXTEND) begin
				extend_q <= 1'b1;
			end else begin
				break_q   <= 1'b0;
				extend_q  <= 1'b0;
				note_q    <= note_nxt;
				wave_q    <= wave_nxt;
				volume_q  <= volume_nxt;
				voices_q  <= voices_nxt;
				detune_q  <= detune_nxt;
				cutoff_q  <= cutoff_nxt;
				e_atk_q   <= e_atk_nxt;
				e_decay_q <= e_decay_nxt;
				e_sus_q   <= e_sus_nxt;
				e_rel_q   <= e_rel_nxt;
				h_atk_q   <= h_atk_nxt;
				h_body_q  <= h_body_nxt;
				h_tail_q  <= h_tail_nxt;
				h_noise_q <= h_noise_nxt;
			end
		end
	end

endmodule

@@ design/kssc_queue.sv @@
// Two-entry queue of write lists between the front end and the back end.
// Depends on kssc_pkg.
module kssc_queue import kssc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	input  logic pop,
	output rec_t head,
	output logic empty,
	output logic full
);

	rec_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign head  = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/kssc_back.sv @@
// Back end: takes write lists from the queue and sends their writes one per
// cycle, unless result_ready stalls the output, through a registered output. Depends on kssc_pkg.
module kssc_back import kssc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rec_t              head,
	input  logic              empty,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [2:0]        port,
	output logic [DATA_W-1:0] data,
	output logic              last
);

	rec_t              cur_q;
	logic              cur_valid_q;
	logic [1:0]        idx_q;
	logic              valid_q, last_q;
	logic [2:0]        port_q;
	logic [DATA_W-1:0] data_q;
	logic              out_free, at_last, send;

	assign out_free = !valid_q || result_ready;
	assign at_last  = (idx_q == cur_q.last_idx);
	assign send     = out_free && cur_valid_q;
	assign pop      = !empty && (!cur_valid_q || (send && at_last));

	// Current write list and position in it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (send) begin
			if (at_last) begin
				cur_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (send) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (send) begin
			port_q <= cur_q.port[idx_q];
			data_q <= cur_q.data[idx_q];
			last_q <= at_last;
		end
	end

	assign result_valid = valid_q;
	assign port         = port_q;
	assign data         = data_q;
	assign last         = last_q;

endmodule

@@ design/keyboard_scan_synth_controller.sv @@
// Keyboard scan synth controller top level: front end, write-list queue, back end.
// A code gives 0 to 4 writes; they pass the queue, current-list and output registers.
// Writes leave at one per cycle while result_ready does not stall the output.
// Scan codes are taken every cycle while the two-entry queue has room.
// Asynchronous active-low reset restores the key state and synth defaults at once.
// Depends on kssc_pkg, kssc_front, kssc_queue and kssc_back.
module keyboard_scan_synth_controller import kssc_pkg::*; #(
	parameter int NOTE_KEYS = 21
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              scan_valid,
	output logic              scan_ready,
	input  logic [7:0]        scan_code,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [2:0]        port,
	output logic [DATA_W-1:0] data,
	output logic              last
);

	logic accept, push, pop, empty, full;
	rec_t rec, head;

	assign scan_ready = !full;
	assign accept     = scan_valid && scan_ready;

	// Classification and state update.
	kssc_front #(.NOTE_KEYS(NOTE_KEYS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.scan_code (scan_code),
		.push      (push),
		.rec       (rec)
	);

	// Decoupling queue.
	kssc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (rec),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	// Write sequencing.
	kssc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.port         (port),
		.data         (data),
		.last         (last)
	);

endmodule

@@ design/kssc_checker.sv @@
// Port-level checks for the keyboard scan synth controller and the bind that attaches them.
// Depends on kssc_pkg and the top level's port names.
module kssc_checker import kssc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input logic [2:0]        port,
	input logic [DATA_W-1:0] data,
	input logic              last
);

	// Every transaction sequence ends with the key-LED write.
	a_last_is_leds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> port == PORT_LEDS)
		else $error("final write is not to the key-LED port");

	// A key-LED write always closes its sequence.
	a_leds_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && port == PORT_LEDS |-> last)
		else $error("key-LED write without last");

	// A test request carries the value one and never closes its sequence.
	a_test_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && port == PORT_TEST |-> data == 32'd1 && !last)
		else $error("bad test request write");

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(port) && $stable(data) && $stable(last))
		else $error("result changed while stalled");

endmodule

bind keyboard_scan_synth_controller kssc_checker u_kssc_checker (.*);
